// ===== rtl/tcq_pkg.sv =====
package tcq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int TICKET_W    = 16;
    localparam int AGE_W       = 8;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    // Request kinds carried on the input tuser.
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] REG_FIRST_TKT  = 2'd2;

    localparam logic [AGE_W-1:0]    LOW_LIMIT_RST  = 8'd9;
    localparam logic [AGE_W-1:0]    HIGH_LIMIT_RST = 8'd60;
    localparam logic [TICKET_W-1:0] FIRST_TKT_RST  = 16'd999;

    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic [AGE_W-1:0]    age;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic               push_front;
        logic               push_back;
        logic               pop;
        logic [COUNT_W-1:0] fill;
    } chain_ctrl_t;

endpackage

// ===== rtl/tcq_cell.sv =====
module tcq_cell (
    input  logic            aclk,
    input  tcq_pkg::cell_op_t op,
    input  tcq_pkg::entry_t left_entry,
    input  tcq_pkg::entry_t right_entry,
    input  tcq_pkg::entry_t new_entry,
    output tcq_pkg::entry_t entry
);

    tcq_pkg::entry_t entry_reg;
    tcq_pkg::entry_t entry_next;

    always_comb begin
        case (op)
            tcq_pkg::CELL_HOLD:       entry_next = entry_reg;
            tcq_pkg::CELL_LOAD:       entry_next = new_entry;
            tcq_pkg::CELL_FROM_LEFT:  entry_next = left_entry;
            tcq_pkg::CELL_FROM_RIGHT: entry_next = right_entry;
            default:                  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/tcq_chain.sv =====
module tcq_chain (
    input  logic                 aclk,
    input  tcq_pkg::chain_ctrl_t ctrl,
    input  tcq_pkg::entry_t      new_entry,
    output tcq_pkg::entry_t      head_entry
);

    tcq_pkg::entry_t   cell_entry [tcq_pkg::QUEUE_DEPTH];
    tcq_pkg::cell_op_t cell_op    [tcq_pkg::QUEUE_DEPTH];

    // Cell 0 is the head. A push at the head moves every entry one cell
    // towards the tail, a pop moves them one cell towards the head, and an
    // append writes only the first free cell.
    for (genvar i = 0; i < tcq_pkg::QUEUE_DEPTH; i++) begin : g_cell
        tcq_pkg::entry_t left_entry;
        tcq_pkg::entry_t right_entry;

        if (i == 0) begin : g_first
            assign left_entry = new_entry;
        end else begin : g_inner_l
            assign left_entry = cell_entry[i-1];
        end

        if (i == tcq_pkg::QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_inner_r
            assign right_entry = cell_entry[i+1];
        end

        always_comb begin
            if (ctrl.push_front) begin
                cell_op[i] = tcq_pkg::CELL_FROM_LEFT;
            end else if (ctrl.push_back && ctrl.fill == tcq_pkg::COUNT_W'(i)) begin
                cell_op[i] = tcq_pkg::CELL_LOAD;
            end else if (ctrl.pop) begin
                cell_op[i] = tcq_pkg::CELL_FROM_RIGHT;
            end else begin
                cell_op[i] = tcq_pkg::CELL_HOLD;
            end
        end

        tcq_cell u_cell (
            .aclk        (aclk),
            .op          (cell_op[i]),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .new_entry   (new_entry),
            .entry       (cell_entry[i])
        );
    end

    assign head_entry = cell_entry[0];

endmodule

// ===== rtl/two_class_ticket_queue.sv =====
// Ticketing queue of 16 entries held in a row of shifting cells, head in the
// first cell. Every request returns exactly one result, which sits in an
// output register from the cycle after acceptance until it is taken; a new
// request is taken in the same cycle as the previous result leaves, so one
// request per cycle is sustained and the rate is set only by the output
// side. An add issues ticket first_ticket plus the count of adds not dropped
// so far (modulo 65536), and pushes an urgent entry (age at or below the low
// limit or at or above the high limit) at the head, shifting the whole row;
// other entries, and any add to an empty queue, go to the tail. A full
// queue drops the add with status 2, an empty one answers pop and peek with
// status 1. Limits and first ticket sit at APB byte addresses 0, 4 and 8;
// the user must write them only while no request is in flight, which the
// block does not enforce; there is no clearing pass after reset.
module two_class_ticket_queue (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] patient_age
    input  logic [1:0]  s_tuser,   // [1:0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] ticket_number, [23:16] entry_age,
                                   // [28:24] waiting_count, [31:29] zero
    output logic [2:0]  m_tuser,   // [1:0] status, [2] went_to_head

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tcq_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tcq_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tcq_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [tcq_pkg::AGE_W-1:0]    low_limit_reg;
    logic [tcq_pkg::AGE_W-1:0]    high_limit_reg;
    logic [tcq_pkg::TICKET_W-1:0] first_tkt_reg;
    logic [tcq_pkg::TICKET_W-1:0] issued_reg;
    logic [tcq_pkg::TICKET_W-1:0] issued_next;
    logic [tcq_pkg::COUNT_W-1:0]  count_reg;
    logic [tcq_pkg::COUNT_W-1:0]  count_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [tcq_pkg::STATUS_W-1:0] out_status_reg;
    logic [tcq_pkg::STATUS_W-1:0] out_status_next;
    tcq_pkg::entry_t              out_entry_reg;
    tcq_pkg::entry_t              out_entry_next;
    logic                         out_head_reg;
    logic                         out_head_next;
    logic [tcq_pkg::COUNT_W-1:0]  out_count_reg;

    logic                         accept;
    logic                         cfg_write;
    logic                         q_empty;
    logic                         q_full;
    logic                         urgent;
    logic                         add_ok;
    logic                         pop_ok;
    logic [tcq_pkg::REQ_W-1:0]    req;
    logic [tcq_pkg::AGE_W-1:0]    age;
    tcq_pkg::entry_t              new_entry;
    tcq_pkg::entry_t              head_entry;
    tcq_pkg::chain_ctrl_t         ctrl;

    assign req       = s_tuser;
    assign age       = s_tdata;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign q_empty   = (count_reg == '0);
    assign q_full    = (count_reg == tcq_pkg::COUNT_W'(tcq_pkg::QUEUE_DEPTH));
    assign urgent    = (age <= low_limit_reg) || (age >= high_limit_reg);
    assign add_ok    = accept && (req == tcq_pkg::REQ_ADD) && !q_full;
    assign pop_ok    = accept && (req == tcq_pkg::REQ_POP) && !q_empty;

    assign new_entry.ticket = first_tkt_reg + issued_reg;
    assign new_entry.age    = age;

    assign ctrl.push_front = add_ok && !q_empty && urgent;
    assign ctrl.push_back  = add_ok && (q_empty || !urgent);
    assign ctrl.pop        = pop_ok;
    assign ctrl.fill       = count_reg;

    tcq_chain u_chain (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .new_entry  (new_entry),
        .head_entry (head_entry)
    );

    always_comb begin
        count_next  = count_reg;
        issued_next = issued_reg;
        if (add_ok) begin
            count_next  = count_reg + tcq_pkg::COUNT_W'(1);
            issued_next = issued_reg + tcq_pkg::TICKET_W'(1);
        end else if (pop_ok) begin
            count_next = count_reg - tcq_pkg::COUNT_W'(1);
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = tcq_pkg::ST_OK;
        out_entry_next  = '0;
        out_head_next   = 1'b0;
        if (accept) begin
            out_valid_next = 1'b1;
        end
        case (req)
            tcq_pkg::REQ_ADD: begin
                if (q_full) begin
                    out_status_next = tcq_pkg::ST_FULL;
                end else begin
                    out_entry_next = new_entry;
                    out_head_next  = ctrl.push_front;
                end
            end
            tcq_pkg::REQ_POP, tcq_pkg::REQ_PEEK: begin
                if (q_empty) begin
                    out_status_next = tcq_pkg::ST_EMPTY;
                end else begin
                    out_entry_next = head_entry;
                end
            end
            tcq_pkg::REQ_COUNT: begin
                out_status_next = tcq_pkg::ST_OK;
            end
            default: begin
                out_status_next = tcq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            issued_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_head_reg   <= out_head_next;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_count_reg, out_entry_reg.age, out_entry_reg.ticket};
    assign m_tuser  = {out_head_reg, out_status_reg};

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= tcq_pkg::LOW_LIMIT_RST;
            high_limit_reg <= tcq_pkg::HIGH_LIMIT_RST;
            first_tkt_reg  <= tcq_pkg::FIRST_TKT_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                tcq_pkg::REG_LOW_LIMIT:  low_limit_reg  <= pwdata[tcq_pkg::AGE_W-1:0];
                tcq_pkg::REG_HIGH_LIMIT: high_limit_reg <= pwdata[tcq_pkg::AGE_W-1:0];
                tcq_pkg::REG_FIRST_TKT:  first_tkt_reg  <= pwdata[tcq_pkg::TICKET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tcq_pkg::REG_LOW_LIMIT:  prdata = tcq_pkg::CFG_DATA_W'(low_limit_reg);
            tcq_pkg::REG_HIGH_LIMIT: prdata = tcq_pkg::CFG_DATA_W'(high_limit_reg);
            tcq_pkg::REG_FIRST_TKT:  prdata = tcq_pkg::CFG_DATA_W'(first_tkt_reg);
            default:                 prdata = '0;
        endcase
    end

    // The fill level never passes the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= tcq_pkg::COUNT_W'(tcq_pkg::QUEUE_DEPTH))
        else $error("queue fill level beyond its depth");

    // A successful pop lowers the fill level by exactly one.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ok |=> count_reg == $past(count_reg) - tcq_pkg::COUNT_W'(1))
        else $error("pop did not lower the fill level by one");

    // A dropped add carries no ticket and no head flag.
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == tcq_pkg::ST_FULL) |->
            (out_entry_reg == '0 && !out_head_reg))
        else $error("dropped add returned entry data");

    // The reported fill level of a result matches the queue after it.
    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_count_reg == count_reg)
        else $error("result fill level differs from the queue");

endmodule
